[hdl/sie_pkg.sv]
// ============================================================================
// sie_pkg
// Shared types and constants for the instruction executor: opcodes, sizes
// of the register file and data memory, and the ALU result bundle.
// ============================================================================
`default_nettype none

package sie_pkg;

    // Storage sizes
    localparam int REG_COUNT   = 32;
    localparam int DATA_WORDS  = 4096;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int DATA_ADDR_W = $clog2(DATA_WORDS);

    // Fixed field widths
    localparam int WORD_W  = 32;
    localparam int PC_W    = 16;
    localparam int RIDX_W  = 5;
    localparam int OP_W    = 4;
    localparam logic [PC_W-1:0] PC_STEP = 16'd4;

    // Opcodes; code 15 has no meaning and runs as NOP
    typedef enum logic [OP_W-1:0] {
        OP_NOP   = 4'd0,
        OP_MOVC  = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_MUL   = 4'd4,
        OP_AND   = 4'd5,
        OP_OR    = 4'd6,
        OP_XOR   = 4'd7,
        OP_LOAD  = 4'd8,
        OP_LDR   = 4'd9,
        OP_STORE = 4'd10,
        OP_BZ    = 4'd11,
        OP_BNZ   = 4'd12,
        OP_JUMP  = 4'd13,
        OP_HALT  = 4'd14
    } opcode_t;

    // What the execute stage hands to the control
    typedef struct packed {
        logic [WORD_W-1:0] result;     // ALU / MOVC value (loads take memory data)
        logic              wr;         // writes a register (before range check)
        logic              sets_zero;  // ADD, SUB, MUL
        logic              is_load;
        logic              is_store;
        logic              is_mem;     // any memory access
        logic              addr_ok;    // effective address inside data memory
        logic [WORD_W-1:0] mem_addr;
        logic [PC_W-1:0]   next_pc;
        logic              halt;
    } alu_res_t;

endpackage

`default_nettype wire

[hdl/sie_alu.sv]
// ============================================================================
// sie_alu
// Execute stage: arithmetic and logic, effective address and range check,
// branch and jump target selection.
// ============================================================================
`default_nettype none

module sie_alu
    import sie_pkg::*;
(
    input  wire opcode_t           op,
    input  wire logic [PC_W-1:0]   pc,
    input  wire logic [WORD_W-1:0] a,
    input  wire logic [WORD_W-1:0] b,
    input  wire logic [WORD_W-1:0] imm,
    input  wire logic              zero_flag,
    output alu_res_t               res
);

    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   addr;
    logic [PC_W-1:0]     pc_plus4;
    logic [PC_W-1:0]     pc_rel;

    // Single multiplier; only the low half is formed
    assign prod     = a * b;
    assign pc_plus4 = pc + PC_STEP;
    assign pc_rel   = pc + imm[PC_W-1:0];

    // Effective address: LDR uses rs1+rs2, STORE rs2+imm, LOAD rs1+imm
    always_comb
    begin
        unique case (op)
            OP_LDR:   addr = a + b;
            OP_STORE: addr = b + imm;
            default:  addr = a + imm;
        endcase
    end

    always_comb
    begin
        res           = '0;
        res.mem_addr  = addr;
        res.addr_ok   = !addr[WORD_W-1] && (addr < WORD_W'(DATA_WORDS));
        res.next_pc   = pc_plus4;
        unique case (op)
            OP_MOVC:
            begin
                res.result = imm;
                res.wr     = 1'b1;
            end
            OP_ADD:
            begin
                res.result    = a + b;
                res.wr        = 1'b1;
                res.sets_zero = 1'b1;
            end
            OP_SUB:
            begin
                res.result    = a - b;
                res.wr        = 1'b1;
                res.sets_zero = 1'b1;
            end
            OP_MUL:
            begin
                res.result    = prod;
                res.wr        = 1'b1;
                res.sets_zero = 1'b1;
            end
            OP_AND:
            begin
                res.result = a & b;
                res.wr     = 1'b1;
            end
            OP_OR:
            begin
                res.result = a | b;
                res.wr     = 1'b1;
            end
            OP_XOR:
            begin
                res.result = a ^ b;
                res.wr     = 1'b1;
            end
            OP_LOAD, OP_LDR:
            begin
                res.is_load = 1'b1;
                res.is_mem  = 1'b1;
                res.wr      = res.addr_ok;
            end
            OP_STORE:
            begin
                res.is_store = 1'b1;
                res.is_mem   = 1'b1;
                res.result   = a;  // store data
            end
            OP_BZ:
            begin
                if (zero_flag)
                    res.next_pc = pc_rel;
            end
            OP_BNZ:
            begin
                if (!zero_flag)
                    res.next_pc = pc_rel;
            end
            OP_JUMP:
            begin
                res.next_pc = a[PC_W-1:0] + imm[PC_W-1:0];
            end
            OP_HALT:
            begin
                res.halt    = 1'b1;
                res.next_pc = pc;
            end
            default:
            begin
                res.wr = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/simple_isa_instruction_executor_top.sv]
// ============================================================================
// simple_isa_instruction_executor_top
// Executes one decoded instruction per item against a register file and a
// data memory, both held in synchronous RAMs, and returns one result item.
// ============================================================================
// After reset the block zeroes all DATA_WORDS words of the data memory, one
// word a cycle, with s_axis_tready low. Each instruction then runs in steps:
// on accept both source registers are read from the register-file RAM; in
// S_EXEC the block executes (multiply, address, store write and data-memory
// read); in S_FIN it writes the register file and loads the output register.
// The next item is taken only once S_FIN is done and the sequencer is back
// in S_IDLE, so instructions do not overlap; the steps are set by the two
// synchronous RAM reads in series. A finished result waits in the output
// register without holding up the next accept; completion waits only while
// that register is full and m_axis_tready is low.
`default_nettype none

module simple_isa_instruction_executor_top
    import sie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Instruction items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] instr_pc, [20:16] dest_index, [25:21] src_a_index,
    // [30:26] src_b_index, [62:31] immediate, [63] zero
    input  wire logic [63:0] s_axis_tdata,
    // [3:0] req_type
    input  wire logic [3:0]  s_axis_tuser,
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] next_pc, [16] reg_written, [21:17] written_index,
    // [53:22] written_value, [54] zero_flag_out, [55] is_halted,
    // [56] address_fault, [63:57] zero
    output logic [63:0]      m_axis_tdata
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Memories
    logic [WORD_W-1:0] rf_mem [REG_COUNT];
    logic [WORD_W-1:0] dm_mem [DATA_WORDS];
    logic [REG_COUNT-1:0] rf_valid_reg;

    logic [WORD_W-1:0] rf_a_q, rf_b_q, dm_rdata_q;

    // Captured item
    opcode_t           op_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [RIDX_W-1:0] dest_reg, srca_reg, srcb_reg;
    logic [WORD_W-1:0] imm_reg;

    // Execute results
    logic [WORD_W-1:0] res_reg;
    logic              wr_reg, sets_zero_reg, is_load_reg, fault_reg;
    logic [PC_W-1:0]   npc_reg;

    logic [DATA_ADDR_W-1:0] clr_cnt_reg;
    logic zero_flag_reg, halted_reg;
    logic m_valid_reg;
    logic [63:0] m_data_reg;

    logic in_accept, fin_go, clr_done;
    logic [WORD_W-1:0] op_a, op_b;
    alu_res_t alu;
    logic dm_we;
    logic [DATA_ADDR_W-1:0] dm_waddr;
    logic [WORD_W-1:0] dm_wdata;
    logic [WORD_W-1:0] fin_value;
    logic fin_wr, rf_we, zf_new;
    logic [63:0] fin_data;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign fin_go        = (state_reg == S_FIN) && (!m_valid_reg || m_axis_tready);
    assign clr_done      = (clr_cnt_reg == DATA_ADDR_W'(DATA_WORDS - 1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_done) state_next = S_IDLE;
            S_IDLE:  if (in_accept) state_next = S_EXEC;
            S_EXEC:  state_next = S_FIN;
            S_FIN:   if (fin_go) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Capture the item on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= opcode_t'(s_axis_tuser);
            pc_reg   <= s_axis_tdata[15:0];
            dest_reg <= s_axis_tdata[20:16];
            srca_reg <= s_axis_tdata[25:21];
            srcb_reg <= s_axis_tdata[30:26];
            imm_reg  <= s_axis_tdata[62:31];
        end
    end

    // Register file: two registered read ports, addressed on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rf_a_q <= rf_mem[s_axis_tdata[21 +: REG_IDX_W]];
            rf_b_q <= rf_mem[s_axis_tdata[26 +: REG_IDX_W]];
        end
        if (rf_we)
            rf_mem[dest_reg[REG_IDX_W-1:0]] <= fin_value;
    end

    // Unwritten or out-of-range registers read as zero
    assign op_a = ((32'(srca_reg) < 32'(REG_COUNT)) && rf_valid_reg[srca_reg[REG_IDX_W-1:0]])
                  ? rf_a_q : '0;
    assign op_b = ((32'(srcb_reg) < 32'(REG_COUNT)) && rf_valid_reg[srcb_reg[REG_IDX_W-1:0]])
                  ? rf_b_q : '0;

    sie_alu u_alu (
        .op        (op_reg),
        .pc        (pc_reg),
        .a         (op_a),
        .b         (op_b),
        .imm       (imm_reg),
        .zero_flag (zero_flag_reg),
        .res       (alu)
    );

    // Data memory: clearing sweep or store on the write port
    assign dm_we    = (state_reg == S_CLEAR)
                   || ((state_reg == S_EXEC) && alu.is_store && alu.addr_ok && !halted_reg);
    assign dm_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : alu.mem_addr[DATA_ADDR_W-1:0];
    assign dm_wdata = (state_reg == S_CLEAR) ? '0 : alu.result;

    always_ff @(posedge clk)
    begin
        if (dm_we)
            dm_mem[dm_waddr] <= dm_wdata;
        if (state_reg == S_EXEC)
            dm_rdata_q <= dm_mem[alu.mem_addr[DATA_ADDR_W-1:0]];
    end

    // Execute results
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            res_reg       <= alu.result;
            wr_reg        <= alu.wr && (32'(dest_reg) < 32'(REG_COUNT));
            sets_zero_reg <= alu.sets_zero;
            is_load_reg   <= alu.is_load;
            fault_reg     <= alu.is_mem && !alu.addr_ok;
            npc_reg       <= alu.next_pc;
        end
    end

    // Completion: writeback and result assembly
    assign fin_value = is_load_reg ? dm_rdata_q : res_reg;
    assign fin_wr    = wr_reg && !halted_reg;
    assign rf_we     = fin_go && fin_wr;
    assign zf_new    = (!halted_reg && sets_zero_reg) ? (res_reg == '0) : zero_flag_reg;

    always_comb
    begin
        fin_data = '0;
        if (halted_reg)
        begin
            fin_data[15:0] = pc_reg;
            fin_data[54]   = zero_flag_reg;
            fin_data[55]   = 1'b1;
        end
        else
        begin
            fin_data[15:0]  = npc_reg;
            fin_data[16]    = fin_wr;
            fin_data[21:17] = fin_wr ? dest_reg : '0;
            fin_data[53:22] = fin_wr ? fin_value : '0;
            fin_data[54]    = zf_new;
            fin_data[55]    = alu.halt;
            fin_data[56]    = fault_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            zero_flag_reg <= 1'b0;
            halted_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_valid_reg[dest_reg[REG_IDX_W-1:0]] <= 1'b1;
            if (fin_go)
            begin
                zero_flag_reg <= zf_new;
                if (alu.halt)
                    halted_reg <= 1'b1;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
            m_data_reg <= fin_data;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during memory clear");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed next cycle");

    a_no_write_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (rf_we || ((state_reg == S_EXEC) && dm_we)) |-> !halted_reg)
        else $error("state written after halt");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && dm_we) |-> alu.addr_ok)
        else $error("store to address outside data memory");

    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go && fault_reg |-> !rf_we)
        else $error("register written on address fault");

endmodule

`default_nettype wire
